[src/per_bin_running_mean_variance_unit_assert.svh]
// Assertion macros shared by the per-bin running mean/variance unit
`ifndef PER_BIN_RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define PER_BIN_RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH

// an implication that must hold on every clock edge out of reset
`define PBMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbmv check failed");

// an implication checked in the cycle after the antecedent
`define PBMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbmv check failed");

`endif

[src/pbmv_pkg.sv]
package pbmv_pkg;
	localparam int unsigned DEF_BINS = 1024;
	localparam int unsigned BIN_W = 10;
	localparam int unsigned GEN_W = 20;
	localparam logic [19:0] GEN_MAX = 20'hFFFFF;
	localparam logic [47:0] SPREAD_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [0:0] {
		CMD_UPDATE   = 1'b0,
		CMD_FINALIZE = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_MUL,
		ST_DIFF,
		ST_DIV,
		ST_MEAN,
		ST_SQ,
		ST_VDIV,
		ST_VAR,
		ST_FDIV,
		ST_SQRT,
		ST_WRITE
	} state_t;
endpackage

[src/per_bin_running_mean_variance_unit.sv]
// Sequence: a first-generation update runs read, multiply, difference and one 64-bit restoring
//   division for the mean; a later update runs three such divisions (one quotient bit per cycle);
//   a finalize runs a division and then a square root. done is registered from the write state.
// Throughput: one request at a time; busy drops with done, next request taken as done ends.
// Reset: arst_n clears control; a clearing pass over all BINS addresses then zeroes both memories
//   (busy high) and the generation count starts at zero. The receiver cannot stall.
module per_bin_running_mean_variance_unit
	import pbmv_pkg::*;
#(
	parameter int unsigned BINS = DEF_BINS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [9:0]  bin,
	input  logic signed [31:0] score,
	input  logic [23:0] multiplier,
	input  logic        last_bin,
	output logic        done,
	output logic [9:0]  bin_out,
	output logic signed [31:0] mean,
	output logic [47:0] spread,
	output logic [19:0] generation
);
	`include "per_bin_running_mean_variance_unit_assert.svh"

	localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;

	logic [31:0] mean_mem [BINS];
	logic [47:0] var_mem  [BINS];

	state_t state_q, state_d;
	logic [AW:0]  clr_q;
	logic         cmd_q, last_q, valid_q;
	logic [9:0]   bin_q;
	logic signed [31:0] score_q;
	logic [23:0]  mult_q;
	logic [19:0]  gcnt_q, g_q;
	logic signed [31:0] rd_mean_s1;
	logic [47:0]  rd_var_s1;
	logic signed [63:0] val_q, diff_q;
	logic [63:0]  mag_q;
	logic [31:0]  new_mean_q;
	logic [47:0]  new_var_q;

	// shared restoring divider: 64-bit dividend, 20-bit divisor
	logic [63:0]  dq_q;
	logic [19:0]  rem_q;
	logic [19:0]  dvs_q;
	logic [6:0]   dcnt_q;
	logic [63:0]  sq_q;
	logic [63:0]  vdiv_q;
	logic         sqsat_q;

	// sqrt unit
	logic [63:0]  sx_q, sr_q, sb_q;

	logic [AW-1:0] addr;
	logic         we;
	logic [31:0]  wmean;
	logic [47:0]  wvar;

	assign addr = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : AW'(bin_q);
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (we) begin
			mean_mem[addr] <= wmean;
			var_mem[addr]  <= wvar;
		end
		rd_mean_s1 <= mean_mem[addr];
		rd_var_s1  <= var_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	logic div_done;
	assign div_done = (dcnt_q == 7'd64);

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		wmean = '0;
		wvar = '0;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_READ;
			ST_CLEAR: begin
				we = 1'b1;
				if (clr_q == (AW+1)'(BINS - 1)) state_d = ST_IDLE;
			end
			ST_READ:  state_d = ST_MUL;
			ST_MUL:   state_d = cmd_q ? ST_FDIV : ST_DIFF;
			ST_DIFF:  state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_MEAN;
			ST_MEAN:  state_d = (g_q > 20'd1) ? ST_SQ : ST_WRITE;
			ST_SQ:    if (div_done) state_d = ST_VDIV;
			ST_VDIV:  if (div_done) state_d = ST_VAR;
			ST_VAR:   state_d = ST_WRITE;
			ST_FDIV:  if (div_done) state_d = ST_SQRT;
			ST_SQRT:  if (sb_q == 64'd0) state_d = ST_WRITE;
			ST_WRITE: begin
				we = valid_q;
				wmean = new_mean_q;
				wvar = new_var_q;
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// squared magnitude: a < 2^43, built from 32-bit limbs in the first cycles of the mean
	// division, a^2 = a0^2 + 2*a1*a0*2^32 + a1^2*2^64
	logic [85:0] sqacc_q;
	logic [31:0] sq_opa, sq_opb;
	logic [63:0] sq_prod;
	logic [63:0] sq_lo;
	assign sq_opa = (dcnt_q == 7'd0) ? mag_q[31:0] : {21'd0, mag_q[42:32]};
	assign sq_opb = (dcnt_q == 7'd2) ? {21'd0, mag_q[42:32]} : mag_q[31:0];
	assign sq_prod = sq_opa * sq_opb;
	assign sq_lo = sqacc_q[79:16];

	logic [20:0] rtrial;
	logic [21:0] rsub;
	assign rtrial = {rem_q, dq_q[63]};
	assign rsub = {1'b0, rtrial} - {2'b0, dvs_q};

	logic signed [63:0] nm_w;
	logic [63:0] sum_w;
	assign nm_w = diff_q[63] ? 64'(rd_mean_s1) - $signed(dq_q)
		: 64'(rd_mean_s1) + $signed(dq_q);
	assign sum_w = 64'(rd_var_s1) - vdiv_q + sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			gcnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_WRITE);
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_WRITE && !cmd_q && last_q && gcnt_q != GEN_MAX)
				gcnt_q <= gcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= command;
				bin_q <= bin;
				score_q <= score;
				mult_q <= multiplier;
				last_q <= last_bin;
				valid_q <= ({22'd0, bin} < 32'(BINS));
				g_q <= (command == CMD_FINALIZE) ? gcnt_q :
					((gcnt_q != GEN_MAX) ? gcnt_q + 1'b1 : GEN_MAX);
			end
			ST_MUL: begin
				// arithmetic shift is floor division by 2^16
				val_q <= (64'(score_q) * $signed({1'b0, mult_q})) >>> 16;
				new_mean_q <= rd_mean_s1;
				new_var_q <= rd_var_s1;
				dq_q <= 64'(rd_var_s1);
				rem_q <= '0;
				dcnt_q <= '0;
				dvs_q <= (g_q == 20'd0) ? 20'd1 : g_q;
			end
			ST_DIFF: begin
				diff_q <= val_q - 64'(rd_mean_s1);
				mag_q <= (val_q - 64'(rd_mean_s1) < 0) ? 64'(rd_mean_s1) - val_q
					: val_q - 64'(rd_mean_s1);
				dq_q <= (val_q - 64'(rd_mean_s1) < 0) ? 64'(rd_mean_s1) - val_q
					: val_q - 64'(rd_mean_s1);
				rem_q <= '0;
				dcnt_q <= '0;
			end
			ST_MEAN: begin
				if (nm_w > 64'sd2147483647) new_mean_q <= 32'h7FFF_FFFF;
				else if (nm_w < -64'sd2147483648) new_mean_q <= 32'h8000_0000;
				else new_mean_q <= nm_w[31:0];
				// diff^2 / g: divide floor(a^2 / 2^16) by g
				sqsat_q <= (sqacc_q[85:80] != 0);
				dq_q <= sq_lo;
				rem_q <= '0;
				dcnt_q <= '0;
			end
			ST_VAR: begin
				if (sqsat_q || sum_w > 64'(SPREAD_MAX)) new_var_q <= SPREAD_MAX;
				else new_var_q <= sum_w[47:0];
			end
			ST_SQRT: begin
				if (sb_q != 0) begin
					if (sx_q >= sr_q + sb_q) begin
						sx_q <= sx_q - (sr_q + sb_q);
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q <= sb_q >> 2;
				end else begin
					new_var_q <= sr_q[47:0];
				end
			end
			default: ;
		endcase

		if (state_q == ST_DIV || state_q == ST_SQ || state_q == ST_VDIV || state_q == ST_FDIV) begin
			if (!div_done) begin
				dcnt_q <= dcnt_q + 1'b1;
				if (!rsub[21]) begin
					rem_q <= rsub[19:0];
					dq_q <= {dq_q[62:0], 1'b1};
				end else begin
					rem_q <= rtrial[19:0];
					dq_q <= {dq_q[62:0], 1'b0};
				end
			end else begin
				rem_q <= '0;
				dcnt_q <= '0;
				if (state_q == ST_SQ) begin
					sq_q <= dq_q;
					dq_q <= 64'(rd_var_s1);
					dvs_q <= g_q - 1'b1;
				end
				if (state_q == ST_VDIV) vdiv_q <= dq_q;
				if (state_q == ST_DIV) begin
					// keep the quotient for ST_MEAN; the divisor g set in ST_MUL is reused for diff^2/g
				end
				if (state_q == ST_FDIV) begin
					sx_q <= {dq_q[47:0], 16'd0};
					sr_q <= '0;
					sb_q <= 64'h4000_0000_0000_0000;
				end
			end
		end

		if (state_q == ST_DIV) begin
			case (dcnt_q)
				7'd0: sqacc_q <= {22'd0, sq_prod};
				7'd1: sqacc_q <= sqacc_q + ({22'd0, sq_prod} << 33);
				7'd2: sqacc_q <= sqacc_q + ({22'd0, sq_prod} << 64);
				default: ;
			endcase
		end
		// sum of var - var/(g-1) + sq cannot go negative; the sq quotient is flagged if it exceeds 48 bits
		if (state_q == ST_SQ && div_done) sqsat_q <= sqsat_q || (dq_q[63:48] != 0);
	end

	assign bin_out = bin_q;
	assign mean = valid_q ? new_mean_q : 32'sd0;
	assign spread = valid_q ? new_var_q : 48'd0;
	assign generation = g_q;

	`PBMV_ASSERT_IMP(a_done_pulse, clk, arst_n, done, !$past(done))
	`PBMV_ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy && start, state_q != ST_IDLE)
	`PBMV_ASSERT_NEXT(a_write_done, clk, arst_n, state_q == ST_WRITE, done && !busy)
endmodule
